// ===== src/pdfm_pkg.sv =====
// ----------------------------------------------------------------------------
// pdfm_pkg
// Shared widths, constants and types of the PWM duty/frequency meter.
// ----------------------------------------------------------------------------
package pdfm_pkg;

    localparam int unsigned COUNT_BITS = 24;

    localparam int unsigned CNT_W   = COUNT_BITS;
    localparam int unsigned OUT_W   = 24;
    localparam int unsigned DUTY_W  = 7;
    localparam int unsigned CLK_W   = 27;
    localparam int unsigned PRE_W   = 11;
    localparam int unsigned PER_W   = CNT_W + 1;
    localparam int unsigned DVS_W   = PER_W + PRE_W;
    localparam int unsigned DNUM_W  = CNT_W + DUTY_W;
    localparam int unsigned DVD_W   = (DNUM_W > CLK_W) ? DNUM_W : CLK_W;
    localparam int unsigned DCNT_W  = $clog2(DVD_W + 1);
    localparam int unsigned CMP_W   = (CNT_W > OUT_W) ? CNT_W : OUT_W;

    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = CLK_W;

    localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_HZ = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESCALE = 1'd1;

    localparam logic [CLK_W-1:0] CLOCK_HZ_RST = 27'd8000000;
    localparam logic [PRE_W-1:0] PRESCALE_RST = 11'd1024;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [OUT_W-1:0] OUT_MAX = '1;

    typedef enum logic [1:0] {
        PH_WAIT,
        PH_HIGH,
        PH_LOW
    } t_phase;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_DUTY,
        ST_FREQ,
        ST_HOLD
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// ===== src/pdfm_in_if.sv =====
// ----------------------------------------------------------------------------
// pdfm_in_if
// Tick channel: one pin sample per word.
// ----------------------------------------------------------------------------
interface pdfm_in_if;
    logic valid;
    logic ready;
    logic pin_level;

    modport source (output valid, output pin_level, input ready);
    modport sink   (input valid, input pin_level, output ready);
endinterface

// ===== src/pdfm_out_if.sv =====
// ----------------------------------------------------------------------------
// pdfm_out_if
// Result channel: one period measurement per word.
// ----------------------------------------------------------------------------
interface pdfm_out_if;
    logic                         valid;
    logic                         ready;
    logic [pdfm_pkg::OUT_W-1:0]  high_ticks;
    logic [pdfm_pkg::OUT_W-1:0]  low_ticks;
    logic [pdfm_pkg::DUTY_W-1:0] duty_percent;
    logic [pdfm_pkg::CLK_W-1:0]  frequency_hz;
    logic                         saturated;

    modport source (
        output valid, output high_ticks, output low_ticks,
        output duty_percent, output frequency_hz, output saturated,
        input ready
    );
    modport sink (
        input valid, input high_ticks, input low_ticks,
        input duty_percent, input frequency_hz, input saturated,
        output ready
    );
endinterface

// ===== src/pdfm_sdiv.sv =====
// ----------------------------------------------------------------------------
// pdfm_sdiv
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pdfm_sdiv (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [pdfm_pkg::DVD_W-1:0]    i_dividend,
    input  logic [pdfm_pkg::DVS_W-1:0]    i_divisor,
    output logic [pdfm_pkg::DVD_W-1:0]    o_quotient,
    output pdfm_pkg::t_div_stat           o_stat
);

    logic [pdfm_pkg::DVS_W-1:0]  r_rem, n_rem;
    logic [pdfm_pkg::DVD_W-1:0]  r_num, n_num;
    logic [pdfm_pkg::DVS_W-1:0]  r_dvs, n_dvs;
    logic [pdfm_pkg::DCNT_W-1:0] r_cnt, n_cnt;
    logic                        r_busy, n_busy;
    logic                        r_done, n_done;

    logic [pdfm_pkg::DVS_W:0]    w_trial;
    logic [pdfm_pkg::DVS_W:0]    w_diff;
    logic                        w_ge;

    assign w_trial = {r_rem, r_num[pdfm_pkg::DVD_W-1]};
    assign w_diff  = w_trial - {1'b0, r_dvs};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});

    always_comb begin
        n_rem  = r_rem;
        n_num  = r_num;
        n_dvs  = r_dvs;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (r_busy) begin
            n_rem = w_ge ? w_diff[pdfm_pkg::DVS_W-1:0] : w_trial[pdfm_pkg::DVS_W-1:0];
            n_num = {r_num[pdfm_pkg::DVD_W-2:0], w_ge};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == pdfm_pkg::DCNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end else if (i_start) begin
            n_rem  = '0;
            n_num  = i_dividend;
            n_dvs  = i_divisor;
            n_cnt  = pdfm_pkg::DCNT_W'(pdfm_pkg::DVD_W);
            n_busy = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_num <= n_num;
        r_dvs <= n_dvs;
    end

    assign o_quotient  = r_num;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

// ===== src/pwm_duty_frequency_meter.sv =====
// ----------------------------------------------------------------------------
// pwm_duty_frequency_meter
// Input-capture PWM meter: high/low ticks, duty percent and frequency.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake       | word
//  i_in     | in  | valid/ready     | pin_level
//  o_out    | out | valid/ready     | high_ticks, low_ticks, duty_percent,
//           |     |                 | frequency_hz, saturated
//  i_cfg_*  | in  | write enable    | 0 clock_hz, 1 prescale
//
//  A tick word that closes no period leaves the meter idle and ready for the next.
//  A tick that closes a period passes through the start, duty, frequency and
//  hold states: two passes of the serial divider, duty then frequency; the
//  prescale multiply runs alongside the first pass.
//  Synchronous active-low reset; no input taken while a period is computed.
//  The result sits in an output register; a stalled sink holds the next
//  finished result in the hold state.
// ----------------------------------------------------------------------------
module pwm_duty_frequency_meter (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    pdfm_in_if.sink                           i_in,
    pdfm_out_if.source                        o_out,
    input  logic                              i_cfg_we,
    input  logic [pdfm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [pdfm_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    pdfm_pkg::t_state           r_state, n_state;
    pdfm_pkg::t_phase           r_phase, n_phase;
    logic                       r_last, n_last;
    logic [pdfm_pkg::CNT_W-1:0] r_tick, n_tick;
    logic [pdfm_pkg::CNT_W-1:0] r_hcap, n_hcap;
    logic                       r_ovf, n_ovf;

    logic [pdfm_pkg::CNT_W-1:0] r_hi_q, n_hi_q;
    logic [pdfm_pkg::CNT_W-1:0] r_lo_q, n_lo_q;
    logic                       r_sat_q, n_sat_q;
    logic [pdfm_pkg::DUTY_W-1:0] r_duty, n_duty;
    logic [pdfm_pkg::CLK_W-1:0]  r_freq, n_freq;

    logic [pdfm_pkg::CLK_W-1:0] r_clock_hz, n_clock_hz;
    logic [pdfm_pkg::PRE_W-1:0] r_prescale, n_prescale;

    logic [pdfm_pkg::DVS_W-1:0] r_mul_acc, n_mul_acc;
    logic [pdfm_pkg::DVS_W-1:0] r_mul_a, n_mul_a;
    logic [pdfm_pkg::PRE_W-1:0] r_mul_b, n_mul_b;

    logic                        r_o_valid, n_o_valid;
    logic [pdfm_pkg::OUT_W-1:0]  r_o_hi, n_o_hi;
    logic [pdfm_pkg::OUT_W-1:0]  r_o_lo, n_o_lo;
    logic [pdfm_pkg::DUTY_W-1:0] r_o_duty, n_o_duty;
    logic [pdfm_pkg::CLK_W-1:0]  r_o_freq, n_o_freq;
    logic                        r_o_sat, n_o_sat;

    logic                        w_div_start;
    logic [pdfm_pkg::DVD_W-1:0]  w_div_dvd;
    logic [pdfm_pkg::DVS_W-1:0]  w_div_dvs;
    logic [pdfm_pkg::DVD_W-1:0]  w_div_q;
    pdfm_pkg::t_div_stat         w_div_stat;

    logic                        w_accept;
    logic                        w_rise;
    logic                        w_fall;
    logic [pdfm_pkg::CNT_W-1:0]  w_tick_inc;
    logic [pdfm_pkg::PER_W-1:0]  w_period;
    logic [pdfm_pkg::DVD_W-1:0]  w_hi_ext;
    logic                        w_hi_big;
    logic                        w_lo_big;

    assign w_accept   = i_in.valid && (r_state == pdfm_pkg::ST_IDLE);
    assign w_rise     = i_in.pin_level && !r_last;
    assign w_fall     = !i_in.pin_level && r_last;
    assign w_tick_inc = (r_tick == pdfm_pkg::CNT_MAX) ? pdfm_pkg::CNT_MAX : r_tick + 1'b1;
    assign w_period   = pdfm_pkg::PER_W'(r_hi_q) + pdfm_pkg::PER_W'(r_lo_q);
    assign w_hi_ext   = pdfm_pkg::DVD_W'(r_hi_q);
    assign w_hi_big   = pdfm_pkg::CMP_W'(r_hi_q) > pdfm_pkg::CMP_W'(pdfm_pkg::OUT_MAX);
    assign w_lo_big   = pdfm_pkg::CMP_W'(r_lo_q) > pdfm_pkg::CMP_W'(pdfm_pkg::OUT_MAX);

    pdfm_sdiv u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dvd),
        .i_divisor  (w_div_dvs),
        .o_quotient (w_div_q),
        .o_stat     (w_div_stat)
    );

    always_comb begin
        n_state    = r_state;
        n_phase    = r_phase;
        n_last     = r_last;
        n_tick     = r_tick;
        n_hcap     = r_hcap;
        n_ovf      = r_ovf;
        n_hi_q     = r_hi_q;
        n_lo_q     = r_lo_q;
        n_sat_q    = r_sat_q;
        n_duty     = r_duty;
        n_freq     = r_freq;
        n_clock_hz = r_clock_hz;
        n_prescale = r_prescale;
        n_mul_acc  = r_mul_acc;
        n_mul_a    = r_mul_a;
        n_mul_b    = r_mul_b;
        n_o_valid  = r_o_valid;
        n_o_hi     = r_o_hi;
        n_o_lo     = r_o_lo;
        n_o_duty   = r_o_duty;
        n_o_freq   = r_o_freq;
        n_o_sat    = r_o_sat;

        w_div_start = 1'b0;
        w_div_dvd   = (w_hi_ext << 6) + (w_hi_ext << 5) + (w_hi_ext << 2);
        w_div_dvs   = pdfm_pkg::DVS_W'(w_period);

        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pdfm_pkg::CFG_CLOCK_HZ: n_clock_hz = i_cfg_data;
                pdfm_pkg::CFG_PRESCALE: n_prescale = i_cfg_data[pdfm_pkg::PRE_W-1:0];
                default: ;
            endcase
        end

        if (o_out.ready) begin
            n_o_valid = 1'b0;
        end

        // serial shift-add: period * prescale
        if (r_mul_b != '0) begin
            if (r_mul_b[0]) begin
                n_mul_acc = r_mul_acc + r_mul_a;
            end
            n_mul_a = r_mul_a << 1;
            n_mul_b = r_mul_b >> 1;
        end

        unique case (r_state)
            pdfm_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_last = i_in.pin_level;
                    unique case (r_phase)
                        pdfm_pkg::PH_HIGH: begin
                            if (w_fall) begin
                                n_hcap  = r_tick;
                                n_phase = pdfm_pkg::PH_LOW;
                                n_tick  = pdfm_pkg::CNT_W'(1);
                            end else begin
                                n_tick = w_tick_inc;
                                n_ovf  = r_ovf || (w_tick_inc == pdfm_pkg::CNT_MAX);
                            end
                        end
                        pdfm_pkg::PH_LOW: begin
                            if (w_rise) begin
                                n_hi_q  = r_hcap;
                                n_lo_q  = r_tick;
                                n_sat_q = r_ovf;
                                n_ovf   = 1'b0;
                                n_phase = pdfm_pkg::PH_HIGH;
                                n_tick  = pdfm_pkg::CNT_W'(1);
                                n_state = pdfm_pkg::ST_START;
                            end else begin
                                n_tick = w_tick_inc;
                                n_ovf  = r_ovf || (w_tick_inc == pdfm_pkg::CNT_MAX);
                            end
                        end
                        default: begin
                            if (w_rise) begin
                                n_ovf   = 1'b0;
                                n_phase = pdfm_pkg::PH_HIGH;
                                n_tick  = pdfm_pkg::CNT_W'(1);
                            end else begin
                                n_phase = pdfm_pkg::PH_WAIT;
                                n_tick  = w_tick_inc;
                                n_ovf   = r_ovf || (w_tick_inc == pdfm_pkg::CNT_MAX);
                            end
                        end
                    endcase
                end
            end
            pdfm_pkg::ST_START: begin
                w_div_start = 1'b1;
                n_mul_acc   = '0;
                n_mul_a     = pdfm_pkg::DVS_W'(w_period);
                n_mul_b     = (r_prescale == '0) ? pdfm_pkg::PRE_W'(1) : r_prescale;
                n_state     = pdfm_pkg::ST_DUTY;
            end
            pdfm_pkg::ST_DUTY: begin
                if (w_div_stat.done) begin
                    n_duty      = w_div_q[pdfm_pkg::DUTY_W-1:0];
                    w_div_start = 1'b1;
                    w_div_dvd   = pdfm_pkg::DVD_W'(r_clock_hz);
                    w_div_dvs   = r_mul_acc;
                    n_state     = pdfm_pkg::ST_FREQ;
                end
            end
            pdfm_pkg::ST_FREQ: begin
                if (w_div_stat.done) begin
                    n_freq  = w_div_q[pdfm_pkg::CLK_W-1:0];
                    n_state = pdfm_pkg::ST_HOLD;
                end
            end
            pdfm_pkg::ST_HOLD: begin
                if (!r_o_valid || o_out.ready) begin
                    n_o_valid = 1'b1;
                    n_o_hi    = w_hi_big ? pdfm_pkg::OUT_MAX : pdfm_pkg::OUT_W'(r_hi_q);
                    n_o_lo    = w_lo_big ? pdfm_pkg::OUT_MAX : pdfm_pkg::OUT_W'(r_lo_q);
                    n_o_duty  = r_duty;
                    n_o_freq  = r_freq;
                    n_o_sat   = r_sat_q || w_hi_big || w_lo_big;
                    n_state   = pdfm_pkg::ST_IDLE;
                end
            end
            default: n_state = pdfm_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= pdfm_pkg::ST_IDLE;
            r_phase    <= pdfm_pkg::PH_WAIT;
            r_last     <= 1'b0;
            r_tick     <= '0;
            r_hcap     <= '0;
            r_ovf      <= 1'b0;
            r_clock_hz <= pdfm_pkg::CLOCK_HZ_RST;
            r_prescale <= pdfm_pkg::PRESCALE_RST;
            r_mul_b    <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_phase    <= n_phase;
            r_last     <= n_last;
            r_tick     <= n_tick;
            r_hcap     <= n_hcap;
            r_ovf      <= n_ovf;
            r_clock_hz <= n_clock_hz;
            r_prescale <= n_prescale;
            r_mul_b    <= n_mul_b;
            r_o_valid  <= n_o_valid;
        end
        r_hi_q    <= n_hi_q;
        r_lo_q    <= n_lo_q;
        r_sat_q   <= n_sat_q;
        r_duty    <= n_duty;
        r_freq    <= n_freq;
        r_mul_acc <= n_mul_acc;
        r_mul_a   <= n_mul_a;
        r_o_hi    <= n_o_hi;
        r_o_lo    <= n_o_lo;
        r_o_duty  <= n_o_duty;
        r_o_freq  <= n_o_freq;
        r_o_sat   <= n_o_sat;
    end

    assign i_in.ready         = (r_state == pdfm_pkg::ST_IDLE);
    assign o_out.valid        = r_o_valid;
    assign o_out.high_ticks   = r_o_hi;
    assign o_out.low_ticks    = r_o_lo;
    assign o_out.duty_percent = r_o_duty;
    assign o_out.frequency_hz = r_o_freq;
    assign o_out.saturated    = r_o_sat;

endmodule

// ===== dv/pdfm_meter_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdfm_meter_checker
// Watches the tick and result channels of the PWM meter, tracks the register
// writes, predicts each period measurement and compares it with what arrives.
// ----------------------------------------------------------------------------
module pdfm_meter_checker
    import pdfm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    pdfm_in_if                    i_ticks,
    pdfm_out_if                   i_meas,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_errors,
    output int                    o_pending
);

    typedef struct packed {
        logic [OUT_W-1:0]  high_ticks;
        logic [OUT_W-1:0]  low_ticks;
        logic [DUTY_W-1:0] duty_percent;
        logic [CLK_W-1:0]  frequency_hz;
        logic              saturated;
    } t_meas;

    t_meas            due_meas[$];
    logic [CLK_W-1:0] clk_hz;
    logic [PRE_W-1:0] presc;
    logic             prev_lvl;
    t_phase           ph;
    logic [CNT_W-1:0] ticks;
    logic [CNT_W-1:0] hi_cap;
    logic             ovf;
    int               errs;

    task automatic bump_count();
        if (ticks != CNT_MAX) ticks++;
        if (ticks == CNT_MAX) ovf = 1'b1;
    endtask

    task automatic close_period();
        t_meas           m;
        longint unsigned per;
        longint unsigned div;
        per = longint'(hi_cap) + longint'(ticks);
        div = longint'((presc == '0) ? PRE_W'(1) : presc) * per;
        m.high_ticks   = hi_cap;
        m.low_ticks    = ticks;
        m.duty_percent = '0;
        m.frequency_hz = '0;
        if (per != 0) begin
            m.duty_percent = DUTY_W'((100 * longint'(hi_cap)) / per);
            m.frequency_hz = CLK_W'(longint'(clk_hz) / div);
        end
        m.saturated = ovf;
        due_meas.push_back(m);
    endtask

    task automatic tick_meter(input logic lvl);
        logic rise;
        logic fall;
        rise     = lvl && !prev_lvl;
        fall     = !lvl && prev_lvl;
        prev_lvl = lvl;
        case (ph)
            PH_HIGH: begin
                if (fall) begin
                    hi_cap = ticks;
                    ph     = PH_LOW;
                    ticks  = 1;
                end else begin
                    bump_count();
                end
            end
            PH_LOW: begin
                if (rise) begin
                    close_period();
                    ovf   = 1'b0;
                    ph    = PH_HIGH;
                    ticks = 1;
                end else begin
                    bump_count();
                end
            end
            default: begin
                if (rise) begin
                    ovf   = 1'b0;
                    ph    = PH_HIGH;
                    ticks = 1;
                end else begin
                    ph = PH_WAIT;
                    bump_count();
                end
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_meas got;
        t_meas exp_m;
        if (!i_rst_n) begin
            due_meas.delete();
            clk_hz   = CLOCK_HZ_RST;
            presc    = PRESCALE_RST;
            prev_lvl = 1'b0;
            ph       = PH_WAIT;
            ticks    = '0;
            hi_cap   = '0;
            ovf      = 1'b0;
            errs     = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CLOCK_HZ: clk_hz = i_cfg_data;
                    CFG_PRESCALE: presc  = i_cfg_data[PRE_W-1:0];
                    default: ;
                endcase
            end
            if (i_ticks.valid && i_ticks.ready) tick_meter(i_ticks.pin_level);
            if (i_meas.valid && i_meas.ready) begin
                got = {i_meas.high_ticks, i_meas.low_ticks, i_meas.duty_percent,
                       i_meas.frequency_hz, i_meas.saturated};
                if (due_meas.size() == 0) begin
                    errs++;
                    if (errs <= 10)
                        $display("%t unexpected word: hi=%0d lo=%0d duty=%0d freq=%0d sat=%0b",
                                 $realtime, got.high_ticks, got.low_ticks,
                                 got.duty_percent, got.frequency_hz, got.saturated);
                end else begin
                    exp_m = due_meas.pop_front();
                    if (got.high_ticks !== exp_m.high_ticks
                            || got.low_ticks !== exp_m.low_ticks
                            || got.duty_percent !== exp_m.duty_percent
                            || got.frequency_hz !== exp_m.frequency_hz
                            || got.saturated !== exp_m.saturated) begin
                        errs++;
                        if (errs <= 10) begin
                            $display("%t word mismatch", $realtime);
                            $display("  exp hi=%0d lo=%0d duty=%0d freq=%0d sat=%0b",
                                     exp_m.high_ticks, exp_m.low_ticks,
                                     exp_m.duty_percent, exp_m.frequency_hz,
                                     exp_m.saturated);
                            $display("  got hi=%0d lo=%0d duty=%0d freq=%0d sat=%0b",
                                     got.high_ticks, got.low_ticks, got.duty_percent,
                                     got.frequency_hz, got.saturated);
                        end
                    end
                end
            end
        end
        o_errors  <= errs;
        o_pending <= due_meas.size();
    end

endmodule

// ===== dv/tb_pwm_duty_frequency_meter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pwm_duty_frequency_meter
// Drives pin samples as tick words: a short edge pattern, then random PWM
// periods mixed with noise under several clock/prescale settings. The
// checker predicts every measurement; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_pwm_duty_frequency_meter;
    import pdfm_pkg::*;

    localparam int        DRAIN   = 2 * DVD_W + 8;
    localparam int        BURST   = 270;
    localparam logic [19:0] OPENING = 20'b0010_1101_0011_1010_1100;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  quiet;
    int                    errors;
    int                    pending;

    pdfm_in_if  tick_ch ();
    pdfm_out_if meas_ch ();

    pwm_duty_frequency_meter dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (tick_ch),
        .o_out      (meas_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    pdfm_meter_checker checker_i (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ticks    (tick_ch),
        .i_meas     (meas_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        meas_ch.ready <= quiet || ($urandom_range(99) >= 28);
    end

    task automatic send_level(input logic lvl);
        while (!quiet && $urandom_range(99) < 28) begin
            tick_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        tick_ch.valid     <= 1'b1;
        tick_ch.pin_level <= lvl;
        do @(posedge i_clk); while (!tick_ch.ready);
    endtask

    task automatic settle();
        tick_ch.valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    // leaves the write enable high; the caller drops it after its last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
    endtask

    function automatic int run_len();
        int r;
        r = $urandom_range(99);
        if (r < 70) return $urandom_range(6, 1);
        if (r < 95) return $urandom_range(60, 7);
        return $urandom_range(400, 61);
    endfunction

    // mostly clean high/low runs, some noise
    task automatic random_burst(input int n);
        int sent;
        int h;
        int l;
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(99) < 85) begin
                h = run_len();
                l = run_len();
                repeat (h) send_level(1'b1);
                repeat (l) send_level(1'b0);
                sent += h + l;
            end else begin
                h = $urandom_range(10, 1);
                repeat (h) send_level(1'($urandom_range(1)));
                sent += h;
            end
        end
    endtask

    initial begin
        logic [CLK_W-1:0] clk_set[6];
        logic [PRE_W-1:0] pre_set[6];
        clk_set = '{27'd100000000, '1, '0, 27'd1, 27'($urandom_range(100000000, 1)),
                    CLOCK_HZ_RST};
        pre_set = '{11'd1, '1, '0, 11'd1024, 11'($urandom_range(1024, 1)), 11'd1};
        i_rst_n           = 1'b0;
        tick_ch.valid     = 1'b0;
        tick_ch.pin_level = 1'b0;
        meas_ch.ready     = 1'b0;
        cfg_we            = 1'b0;
        cfg_idx           = CFG_CLOCK_HZ;
        cfg_data          = '0;
        quiet             = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int k = 19; k >= 0; k--) send_level(OPENING[k]);
        for (int s = 0; s < 6; s++) begin
            settle();
            write_reg(CFG_CLOCK_HZ, clk_set[s]);
            write_reg(CFG_PRESCALE, CFG_DATA_W'(pre_set[s]));
            cfg_we <= 1'b0;
            quiet = (s == 2);
            random_burst(BURST);
            quiet = 1'b0;
        end
        settle();
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #10ms;
        $display("status: fail");
        $finish;
    end

endmodule
